// ----- src/bdce_pkg.sv -----
// shared widths, codes and defaults for the byte delta clip encoder
package bdce_pkg;

    localparam int OP_W   = 2;
    localparam int KIND_W = 2;
    localparam int BYTE_W = 8;
    localparam int VAL_W  = 32;

    // default number of equal bytes in a row that closes a clip
    localparam int MATCH_RUN_DEF = 8;

    // patch bytes per clip on top of its literals: two 32-bit words
    localparam logic [VAL_W-1:0] HEADER_BYTES = VAL_W'(4 * 2);

    typedef enum logic [OP_W-1:0] {
        OP_CMP    = 2'd0,
        OP_TAIL   = 2'd1,
        OP_FINISH = 2'd2
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_HDR  = 2'd0,
        KIND_LIT  = 2'd1,
        KIND_FILL = 2'd2,
        KIND_SUM  = 2'd3
    } t_kind;

endpackage

// ----- src/byte_delta_clip_encoder.sv -----
// byte delta clip encoder: compares new and old byte streams and emits patch clip records
//
// usage: one input transfer carries one stream position (op compare or new-only tail byte)
// or a finish request. each transfer yields zero, one or several result transfers, in
// order, with o_last on the final one of each input. an input whose work yields at most
// one result is taken every cycle, back to back, while i_stall is low. an input that
// yields k results holds the result sequencer, and o_stall stays raised, until the last
// of them moves out (k is at most the larger of MATCH_RUN and 2: held bytes plus the new
// literal, or header plus literal, or fill plus summary). the single result register
// moves one record per cycle while i_stall is low. the first result passes through the
// job pending flags and then the result register. there is no clearing pass after reset.
// while the final result of an item waits on i_stall the next input is still taken; if
// that input yields results, o_stall then stays high until the waiting result moves on.
module byte_delta_clip_encoder #(
    parameter int MATCH_RUN = bdce_pkg::MATCH_RUN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [bdce_pkg::OP_W-1:0]   i_op,
    input  logic [bdce_pkg::BYTE_W-1:0] i_new_byte,
    input  logic [bdce_pkg::BYTE_W-1:0] i_old_byte,
    input  logic                        i_sizes_differ,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [bdce_pkg::KIND_W-1:0] o_kind,
    output logic [bdce_pkg::VAL_W-1:0]  o_value,
    output logic                        o_patch_needed,
    output logic                        o_last
);
    import bdce_pkg::*;

    // match run counter holds 0..MATCH_RUN, held store index 0..MATCH_RUN-1
    localparam int RUN_W = $clog2(MATCH_RUN + 1);
    localparam int IDX_W = (MATCH_RUN > 1) ? $clog2(MATCH_RUN) : 1;
    localparam logic [RUN_W-1:0] RUN_LAST = RUN_W'(MATCH_RUN - 1);
    localparam logic [VAL_W-1:0] RUN_VAL  = VAL_W'(MATCH_RUN);
    localparam logic [VAL_W-1:0] RUN_M1   = VAL_W'(MATCH_RUN - 1);

    // encoder state
    logic              r_in_clip,   n_in_clip;
    logic              r_tail_seen, n_tail_seen;
    logic [VAL_W-1:0]  r_skip,      n_skip;
    logic [VAL_W-1:0]  r_len,       n_len;
    logic [RUN_W-1:0]  r_run,       n_run;
    logic [VAL_W-1:0]  r_total,     n_total;
    logic [BYTE_W-1:0] r_held [MATCH_RUN];

    // held store write request from the current input
    logic              held_we;
    logic [IDX_W-1:0]  held_idx;

    // result job: records still to emit, in the order header, held, literal, fill, summary
    logic              r_hdr_pend,  n_hdr_pend,  d_hdr_pend;
    logic [VAL_W-1:0]  r_hdr_val,   d_hdr_val;
    logic [RUN_W-1:0]  r_flush_cnt, n_flush_cnt, d_flush_cnt;
    logic              r_lit_pend,  n_lit_pend,  d_lit_pend;
    logic [BYTE_W-1:0] r_lit_val,   d_lit_val;
    logic              r_fill_pend, n_fill_pend, d_fill_pend;
    logic [VAL_W-1:0]  r_fill_val,  d_fill_val;
    logic              r_sum_pend,  n_sum_pend,  d_sum_pend;
    logic [VAL_W-1:0]  r_sum_val,   d_sum_val;
    logic              r_sum_pn,    d_sum_pn;

    // result register
    logic              r_out_valid;
    logic [KIND_W-1:0] r_out_kind;
    logic [VAL_W-1:0]  r_out_value;
    logic              r_out_pn;
    logic              r_out_last;

    // sequencer control
    logic              job_busy;
    logic              out_ready;
    logic              pop;
    logic              accept_ok;
    logic              in_acc;
    logic              sel_shift;
    t_kind             sel_kind;
    logic [VAL_W-1:0]  sel_value;
    logic              sel_pn;
    logic              sel_last;

    // finish path helpers
    logic [VAL_W-1:0]  fin_len;
    logic [VAL_W-1:0]  close_len;

    assign job_busy  = r_hdr_pend || (r_flush_cnt != '0) || r_lit_pend
                       || r_fill_pend || r_sum_pend;
    assign out_ready = !r_out_valid || !i_stall;
    assign pop       = job_busy && out_ready;
    // a new job may load once the last record of the current one moves out
    assign accept_ok = !job_busy || (pop && sel_last);
    assign o_stall   = !accept_ok;
    assign in_acc    = i_valid && accept_ok;

    // pick the next record of the job and work out what stays pending
    always_comb begin
        n_hdr_pend  = r_hdr_pend;
        n_flush_cnt = r_flush_cnt;
        n_lit_pend  = r_lit_pend;
        n_fill_pend = r_fill_pend;
        n_sum_pend  = r_sum_pend;
        sel_shift   = 1'b0;
        sel_pn      = 1'b0;
        if (r_hdr_pend) begin
            sel_kind   = KIND_HDR;
            sel_value  = r_hdr_val;
            sel_last   = !((r_flush_cnt != '0) || r_lit_pend || r_fill_pend || r_sum_pend);
            n_hdr_pend = 1'b0;
        end else if (r_flush_cnt != '0) begin
            // held bytes leave from the front of the store, which then shifts down
            sel_kind    = KIND_LIT;
            sel_value   = VAL_W'(r_held[0]);
            sel_last    = (r_flush_cnt == RUN_W'(1))
                          && !(r_lit_pend || r_fill_pend || r_sum_pend);
            n_flush_cnt = r_flush_cnt - RUN_W'(1);
            sel_shift   = 1'b1;
        end else if (r_lit_pend) begin
            sel_kind   = KIND_LIT;
            sel_value  = VAL_W'(r_lit_val);
            sel_last   = !(r_fill_pend || r_sum_pend);
            n_lit_pend = 1'b0;
        end else if (r_fill_pend) begin
            sel_kind    = KIND_FILL;
            sel_value   = r_fill_val;
            sel_last    = !r_sum_pend;
            n_fill_pend = 1'b0;
        end else begin
            sel_kind   = KIND_SUM;
            sel_value  = r_sum_val;
            sel_pn     = r_sum_pn;
            sel_last   = 1'b1;
            n_sum_pend = 1'b0;
        end
    end

    // a finish drops trailing held matches unless a tail was seen
    assign fin_len   = r_tail_seen ? r_len : (r_len - VAL_W'(r_run));
    // clip closed by a full match run: the held run bytes are dropped from its length
    assign close_len = r_len - RUN_M1;

    // decode one input into its job and the next encoder state
    always_comb begin
        n_in_clip   = r_in_clip;
        n_tail_seen = r_tail_seen;
        n_skip      = r_skip;
        n_len       = r_len;
        n_run       = r_run;
        n_total     = r_total;
        held_we     = 1'b0;
        held_idx    = r_run[IDX_W-1:0];
        d_hdr_pend  = 1'b0;
        d_hdr_val   = r_skip;
        d_flush_cnt = '0;
        d_lit_pend  = 1'b0;
        d_lit_val   = i_new_byte;
        d_fill_pend = 1'b0;
        d_fill_val  = close_len;
        d_sum_pend  = 1'b0;
        d_sum_val   = r_total;
        d_sum_pn    = 1'b0;
        case (i_op)
            OP_CMP: begin
                if (!r_tail_seen) begin
                    if (!r_in_clip) begin
                        if (i_new_byte == i_old_byte) begin
                            n_skip = r_skip + VAL_W'(1);
                        end else begin
                            // mismatch opens a clip
                            d_hdr_pend = 1'b1;
                            d_lit_pend = 1'b1;
                            n_skip     = '0;
                            n_in_clip  = 1'b1;
                            n_len      = VAL_W'(1);
                            n_run      = '0;
                        end
                    end else if (i_new_byte != i_old_byte) begin
                        // mismatch inside a clip flushes the held matches
                        d_flush_cnt = r_run;
                        d_lit_pend  = 1'b1;
                        n_len       = r_len + VAL_W'(1);
                        n_run       = '0;
                    end else if (r_run == RUN_LAST) begin
                        // run complete: close the clip, run bytes start the next skip
                        d_fill_pend = 1'b1;
                        d_fill_val  = close_len;
                        n_total     = r_total + close_len + HEADER_BYTES;
                        n_in_clip   = 1'b0;
                        n_len       = '0;
                        n_skip      = RUN_VAL;
                        n_run       = '0;
                    end else begin
                        held_we = 1'b1;
                        n_run   = r_run + RUN_W'(1);
                        n_len   = r_len + VAL_W'(1);
                    end
                end
            end
            OP_TAIL: begin
                n_tail_seen = 1'b1;
                d_lit_pend  = 1'b1;
                n_run       = '0;
                if (!r_in_clip) begin
                    d_hdr_pend = 1'b1;
                    n_skip     = '0;
                    n_in_clip  = 1'b1;
                    n_len      = VAL_W'(1);
                end else begin
                    d_flush_cnt = r_run;
                    n_len       = r_len + VAL_W'(1);
                end
            end
            OP_FINISH: begin
                d_sum_pend = 1'b1;
                if (r_in_clip) begin
                    d_fill_pend = 1'b1;
                    d_fill_val  = fin_len;
                    d_sum_val   = r_total + fin_len + HEADER_BYTES;
                end
                d_sum_pn    = (d_sum_val != '0) || i_sizes_differ;
                // back to the reset state for the next stream pair
                n_in_clip   = 1'b0;
                n_tail_seen = 1'b0;
                n_skip      = '0;
                n_len       = '0;
                n_run       = '0;
                n_total     = '0;
            end
            default: begin
                // unused op: no effect
            end
        endcase
    end

    // encoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_clip   <= 1'b0;
            r_tail_seen <= 1'b0;
            r_skip      <= '0;
            r_len       <= '0;
            r_run       <= '0;
            r_total     <= '0;
        end else if (in_acc) begin
            r_in_clip   <= n_in_clip;
            r_tail_seen <= n_tail_seen;
            r_skip      <= n_skip;
            r_len       <= n_len;
            r_run       <= n_run;
            r_total     <= n_total;
        end
    end

    // held match bytes: appended at the run count, drained from the front
    always_ff @(posedge i_clk) begin
        if (in_acc && held_we) begin
            r_held[held_idx] <= i_new_byte;
        end else if (pop && sel_shift) begin
            for (int i = 0; i < MATCH_RUN - 1; i++) begin
                r_held[i] <= r_held[i+1];
            end
        end
    end

    // job pending flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pend  <= 1'b0;
            r_flush_cnt <= '0;
            r_lit_pend  <= 1'b0;
            r_fill_pend <= 1'b0;
            r_sum_pend  <= 1'b0;
        end else if (in_acc) begin
            r_hdr_pend  <= d_hdr_pend;
            r_flush_cnt <= d_flush_cnt;
            r_lit_pend  <= d_lit_pend;
            r_fill_pend <= d_fill_pend;
            r_sum_pend  <= d_sum_pend;
        end else if (pop) begin
            r_hdr_pend  <= n_hdr_pend;
            r_flush_cnt <= n_flush_cnt;
            r_lit_pend  <= n_lit_pend;
            r_fill_pend <= n_fill_pend;
            r_sum_pend  <= n_sum_pend;
        end
    end

    // job payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_hdr_val  <= d_hdr_val;
            r_lit_val  <= d_lit_val;
            r_fill_val <= d_fill_val;
            r_sum_val  <= d_sum_val;
            r_sum_pn   <= d_sum_pn;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_kind  <= sel_kind;
            r_out_value <= sel_value;
            r_out_pn    <= sel_pn;
            r_out_last  <= sel_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_value        = r_out_value;
    assign o_patch_needed = r_out_pn;
    assign o_last         = r_out_last;

endmodule

// ----- src/bdce_checker.sv -----
// port-level checks for the byte delta clip encoder and their bind
module bdce_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [bdce_pkg::KIND_W-1:0] o_kind,
    input logic [bdce_pkg::VAL_W-1:0]  o_value,
    input logic                        o_patch_needed,
    input logic                        o_last
);
    import bdce_pkg::*;

    // no result left over once reset has been seen
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // patch_needed only ever rides on the summary
    a_pn_summary_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != KIND_SUM) |-> !o_patch_needed)
        else $error("patch_needed set outside summary");

    // the summary always closes the records of its finish
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_SUM) |-> o_last)
        else $error("summary not marked last");

    // a header is always followed by its first literal
    a_header_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_HDR) |-> !o_last)
        else $error("header marked last");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_value)
        && $stable(o_last))
        else $error("stalled result changed");

endmodule

bind byte_delta_clip_encoder bdce_checker u_bdce_checker (.*);
